// ===== design/cihm_pkg.sv =====
// Shared constants, memory word types and the bucket count helper of the integer hash map.
package cihm_pkg;

    localparam int CAPACITY = 1024;
    localparam int BUCKETS  = 2048;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int LINK_W   = $clog2(CAPACITY) + 1;
    localparam int NODE_AW  = $clog2(CAPACITY);
    localparam int HEAD_AW  = $clog2(BUCKETS);
    localparam int CNT_W    = 11;
    localparam int DIV_STEP = 8;
    localparam int DIV_W    = 32;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

    // Reciprocal of 50 scaled by 2**20, exact for 9 * limit up to 9216.
    localparam int RECIP_50 = 20972;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] link;
    } head_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] link;
    } node_word_t;

    // floor(limit * 118 / 100) made odd, computed as limit + floor(9 * limit / 50).
    function automatic logic [CNT_W-1:0] bucket_count_f(input logic [CNT_W-1:0] lim);
        logic [13:0] w;
        logic [28:0] p;
        logic [11:0] b;
        w = {lim, 3'b000} + {3'b000, lim};
        p = 29'(w) * 29'(RECIP_50);
        b = 12'(lim) + 12'(p[28:20]);
        if (!b[0])
        begin
            b = b + 12'd1;
        end
        return b[CNT_W-1:0];
    endfunction

endpackage

// ===== design/cihm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module cihm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/chained_int_hash_map_core.sv =====
// Chained integer hash map: one transaction per operation, remainder unit and chain walk.
// Each operation runs the remainder, a head read and check, a check per chain node visited and an
// action step, plus a write step for an insert into a busy bucket or a remove that unlinks.
// One operation at a time: no new transaction is taken until the result leaves the done state;
// the remainder and the chain node reads set the pace. Clear and spare codes go straight to done.
// Reset, a max_entries write and a clear run a pass over the whole bucket RAM, stalling input.
module chained_int_hash_map_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cihm_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic [cihm_pkg::KEY_W-1:0]    key,
    input  logic [cihm_pkg::VAL_W-1:0]    value_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [cihm_pkg::VAL_W-1:0]    value_out,
    output logic [cihm_pkg::CNT_W-1:0]    entry_count
);

    import cihm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HREAD, S_HCHK, S_NCHK,
        S_ACT, S_INS_W, S_RMH_W, S_RM_FREE, S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   bc_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LINK_W-1:0]  free_head_reg;
    logic [LINK_W-1:0]  fresh_reg;
    logic [HEAD_AW-1:0] clr_idx_reg;
    logic               clr_pend_reg;
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [1:0]         div_cnt_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rem_next;
    head_word_t         hw_reg;
    node_word_t         nw_reg;
    node_word_t         prev_w_reg;
    logic [LINK_W-1:0]  cur_reg;
    logic [LINK_W-1:0]  prev_reg;
    logic               prev_valid_reg;
    logic               hit_reg;
    logic               at_head_reg;
    logic [1:0]         res_status_reg;
    logic [VAL_W-1:0]   res_value_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [VAL_W-1:0]   value_out_reg;
    logic [CNT_W-1:0]   entry_count_reg;

    logic               head_we;
    logic [HEAD_AW-1:0] head_addr;
    head_word_t         head_wdata;
    head_word_t         head_rd;
    logic               node_we;
    logic [NODE_AW-1:0] node_addr;
    node_word_t         node_wdata;
    node_word_t         node_rd;

    logic [1:0]         act_status;
    logic [VAL_W-1:0]   act_value;
    state_t             act_next;
    logic               act_inc;
    logic               act_dec;
    logic               fresh_alloc;
    logic [LINK_W-1:0]  alloc_next;
    logic [CNT_W-1:0]   cfg_limit;

    assign in_stall    = (state_reg != S_IDLE) || cfg_write;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

    assign cfg_limit   = (cfg_data > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cfg_data;
    assign fresh_alloc = (free_head_reg == fresh_reg);
    assign alloc_next  = fresh_alloc ? (free_head_reg + LINK_W'(1)) : node_rd.link;

    cihm_ram #(.WIDTH($bits(head_word_t)), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .addr  (head_addr),
        .wdata (head_wdata),
        .rdata (head_rd)
    );

    cihm_ram #(.WIDTH($bits(node_word_t)), .DEPTH(CAPACITY)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_wdata),
        .rdata (node_rd)
    );

    // Restoring remainder, DIV_STEP dividend bits per cycle.
    always_comb
    begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, div_reg[DIV_W-1-i]};
            if (t >= {1'b0, bc_reg})
            begin
                t = t - {1'b0, bc_reg};
            end
            r = t[CNT_W-1:0];
        end
        rem_next = r;
    end

    // Decision of the action step, shared by the RAM controls and the state update.
    always_comb
    begin
        act_status = ST_OK;
        act_value  = '0;
        act_next   = S_DONE;
        act_inc    = 1'b0;
        act_dec    = 1'b0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (!hit_reg)
                begin
                    act_status = ST_NOT_FOUND;
                end
                else
                begin
                    act_value = at_head_reg ? hw_reg.value : nw_reg.value;
                end
            end
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    act_status = ST_DUPLICATE;
                end
                else if (count_reg >= limit_reg)
                begin
                    act_status = ST_FULL;
                end
                else if (!hw_reg.used)
                begin
                    act_inc = 1'b1;
                end
                else if (free_head_reg >= NIL_LINK)
                begin
                    act_status = ST_FULL;
                end
                else
                begin
                    act_next = S_INS_W;
                end
            end
            OP_SET:
            begin
                if (!hit_reg)
                begin
                    act_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE:
            begin
                if (!hit_reg)
                begin
                    act_status = ST_NOT_FOUND;
                end
                else if (at_head_reg)
                begin
                    if (hw_reg.link != NIL_LINK)
                    begin
                        act_next = S_RMH_W;
                    end
                    else
                    begin
                        act_dec = 1'b1;
                    end
                end
                else
                begin
                    act_next = S_RM_FREE;
                end
            end
            default:
            begin
                act_next = S_DONE;
            end
        endcase
    end

    always_comb
    begin
        head_we    = 1'b0;
        head_addr  = rem_reg;
        head_wdata = hw_reg;
        node_we    = 1'b0;
        node_addr  = cur_reg[NODE_AW-1:0];
        node_wdata = nw_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_addr  = clr_idx_reg;
                head_wdata = '0;
            end
            S_HCHK:
            begin
                node_addr = head_rd.link[NODE_AW-1:0];
            end
            S_NCHK:
            begin
                node_addr = node_rd.link[NODE_AW-1:0];
            end
            S_ACT:
            begin
                if (op_reg == OP_INSERT)
                begin
                    // An empty bucket takes the key in its head slot.
                    head_we    = act_inc;
                    head_wdata = '{used: 1'b1, key: key_reg, value: val_reg, link: NIL_LINK};
                    node_addr  = free_head_reg[NODE_AW-1:0];
                end
                else if (op_reg == OP_SET && hit_reg)
                begin
                    head_we          = at_head_reg;
                    head_wdata.value = val_reg;
                    node_we          = !at_head_reg;
                    node_wdata.value = val_reg;
                end
                else if (op_reg == OP_REMOVE && hit_reg)
                begin
                    if (at_head_reg)
                    begin
                        node_addr       = hw_reg.link[NODE_AW-1:0];
                        head_we         = act_dec;
                        head_wdata.used = 1'b0;
                        head_wdata.link = NIL_LINK;
                    end
                    else if (!prev_valid_reg)
                    begin
                        head_we         = 1'b1;
                        head_wdata.link = nw_reg.link;
                    end
                    else
                    begin
                        node_we         = 1'b1;
                        node_addr       = prev_reg[NODE_AW-1:0];
                        node_wdata      = prev_w_reg;
                        node_wdata.link = nw_reg.link;
                    end
                end
            end
            S_INS_W:
            begin
                // The new node goes second, right after the head.
                node_we         = 1'b1;
                node_addr       = free_head_reg[NODE_AW-1:0];
                node_wdata      = '{key: key_reg, value: val_reg, link: hw_reg.link};
                head_we         = 1'b1;
                head_wdata.link = free_head_reg;
            end
            S_RMH_W:
            begin
                // The second node moves into the head slot and returns to the free list.
                head_we         = 1'b1;
                head_wdata      = '{used: 1'b1, key: node_rd.key, value: node_rd.value,
                                    link: node_rd.link};
                node_we         = 1'b1;
                node_addr       = hw_reg.link[NODE_AW-1:0];
                node_wdata      = node_rd;
                node_wdata.link = free_head_reg;
            end
            S_RM_FREE:
            begin
                node_we         = 1'b1;
                node_wdata.link = free_head_reg;
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            limit_reg       <= '0;
            bc_reg          <= CNT_W'(1);
            count_reg       <= '0;
            free_head_reg   <= '0;
            fresh_reg       <= '0;
            clr_idx_reg     <= '0;
            clr_pend_reg    <= 1'b0;
            div_cnt_reg     <= '0;
            prev_valid_reg  <= 1'b0;
            hit_reg         <= 1'b0;
            at_head_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // A waiting result that leaves is replaced in the same cycle by the done state.
            if (out_valid_reg && !out_stall && (cfg_write || (state_reg != S_DONE)))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                limit_reg     <= cfg_limit;
                bc_reg        <= bucket_count_f(cfg_limit);
                count_reg     <= '0;
                free_head_reg <= '0;
                fresh_reg     <= '0;
                clr_idx_reg   <= '0;
                clr_pend_reg  <= 1'b0;
                state_reg     <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_idx_reg <= clr_idx_reg + HEAD_AW'(1);
                        if (clr_idx_reg == HEAD_AW'(BUCKETS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            op_reg         <= op;
                            key_reg        <= key;
                            val_reg        <= value_in;
                            div_reg        <= {1'b0, key};
                            rem_reg        <= '0;
                            div_cnt_reg    <= '0;
                            hit_reg        <= 1'b0;
                            at_head_reg    <= 1'b0;
                            prev_valid_reg <= 1'b0;
                            res_status_reg <= ST_OK;
                            res_value_reg  <= '0;
                            clr_pend_reg   <= (op == OP_CLEAR);
                            if (op == OP_CLEAR)
                            begin
                                count_reg     <= '0;
                                free_head_reg <= '0;
                                fresh_reg     <= '0;
                                clr_idx_reg   <= '0;
                                state_reg     <= S_DONE;
                            end
                            else if (op > OP_CLEAR)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                    end
                    S_DIV:
                    begin
                        rem_reg     <= rem_next;
                        div_reg     <= div_reg << DIV_STEP;
                        div_cnt_reg <= div_cnt_reg + 2'd1;
                        if (div_cnt_reg == 2'(DIV_W / DIV_STEP - 1))
                        begin
                            state_reg <= S_HREAD;
                        end
                    end
                    S_HREAD:
                    begin
                        state_reg <= S_HCHK;
                    end
                    S_HCHK:
                    begin
                        hw_reg  <= head_rd;
                        cur_reg <= head_rd.link;
                        if (head_rd.used && head_rd.key == key_reg)
                        begin
                            hit_reg     <= 1'b1;
                            at_head_reg <= 1'b1;
                            state_reg   <= S_ACT;
                        end
                        else if (!head_rd.used || head_rd.link == NIL_LINK)
                        begin
                            state_reg <= S_ACT;
                        end
                        else
                        begin
                            state_reg <= S_NCHK;
                        end
                    end
                    S_NCHK:
                    begin
                        nw_reg <= node_rd;
                        if (node_rd.key == key_reg)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_ACT;
                        end
                        else if (node_rd.link == NIL_LINK)
                        begin
                            state_reg <= S_ACT;
                        end
                        else
                        begin
                            prev_reg       <= cur_reg;
                            prev_w_reg     <= node_rd;
                            prev_valid_reg <= 1'b1;
                            cur_reg        <= node_rd.link;
                        end
                    end
                    S_ACT:
                    begin
                        res_status_reg <= act_status;
                        res_value_reg  <= act_value;
                        state_reg      <= act_next;
                        if (act_inc)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (act_dec)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                    S_INS_W:
                    begin
                        free_head_reg <= alloc_next;
                        if (fresh_alloc)
                        begin
                            fresh_reg <= fresh_reg + LINK_W'(1);
                        end
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_DONE;
                    end
                    S_RMH_W:
                    begin
                        free_head_reg <= hw_reg.link;
                        count_reg     <= count_reg - CNT_W'(1);
                        state_reg     <= S_DONE;
                    end
                    S_RM_FREE:
                    begin
                        free_head_reg <= cur_reg;
                        count_reg     <= count_reg - CNT_W'(1);
                        state_reg     <= S_DONE;
                    end
                    S_DONE:
                    begin
                        if (!out_valid_reg || !out_stall)
                        begin
                            out_valid_reg   <= 1'b1;
                            status_reg      <= res_status_reg;
                            value_out_reg   <= res_value_reg;
                            entry_count_reg <= count_reg;
                            state_reg       <= clr_pend_reg ? S_CLEAR : S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
